@@ rtl/wdtl_pkg.sv @@
// Shared types, constants and arithmetic helpers of the three-level wavelet core.
`default_nettype none
package wdtl_pkg;

  localparam int TAPS     = 16;
  localparam int EXT      = TAPS - 1;
  localparam int COEF_W   = 24;
  localparam int TAP_W    = 17;
  localparam int PROD_W   = COEF_W + TAP_W;
  localparam int ACC_W    = 48;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [TAP_W-1:0]  tap_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Low-pass and high-pass partial sums handed from cell to cell
  typedef struct packed {
    acc_t lo;
    acc_t hi;
  } sum_pair_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SIZE,
    ST_BOUND,
    ST_RUN,
    ST_DRAIN,
    ST_READ
  } state_e;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] BAND_A3 = 2'd0;
  localparam logic [1:0] BAND_D3 = 2'd1;
  localparam logic [1:0] BAND_D2 = 2'd2;
  localparam logic [1:0] BAND_D1 = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  // sym8 analysis filters, Q16
  localparam tap_t LO_TAPS [TAPS] = '{
    -17'sd222, -17'sd36, 17'sd2077, 17'sd499, -17'sd9391, -17'sd4016, 17'sd31546, 17'sd50934,
    17'sd23884, -17'sd3404, -17'sd1784, 17'sd3220, 17'sd250, -17'sd980, -17'sd20, 17'sd124
  };
  localparam tap_t HI_TAPS [TAPS] = '{
    -17'sd124, -17'sd20, 17'sd980, 17'sd250, -17'sd3220, -17'sd1784, 17'sd3404, 17'sd23884,
    -17'sd50934, 17'sd31546, 17'sd4016, -17'sd9391, -17'sd499, 17'sd2077, 17'sd36, -17'sd222
  };

  // Round a Q20 sum to Q4 (half up, floor) and saturate to 24 bits
  function automatic coef_t round_sat(acc_t v);
    acc_t               t;
    logic signed [31:0] r;
    t = v + acc_t'(32768);
    r = t[ACC_W-1:16];
    if (r > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (r < -32'sd8388608) begin
      return 24'sh800000;
    end
    return r[COEF_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/wdtl_if.sv @@
// Input and output word channels of the wavelet core.
`default_nettype none
interface wdtl_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] sample;
  logic               final_sample;
  modport source (output valid, action, sample, final_sample, input ready);
  modport sink   (input valid, action, sample, final_sample, output ready);
endinterface

interface wdtl_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] coefficient;
  logic [1:0]         band;
  logic [10:0]        band_length;
  logic               final_coefficient;
  logic [1:0]         status;
  modport source (output valid, coefficient, band, band_length, final_coefficient, status,
                  input ready);
  modport sink   (input valid, coefficient, band, band_length, final_coefficient, status,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/wdtl_cell.sv @@
// One tap cell of the transposed filter chain: multiply, register, add neighbor's sum.
`default_nettype none
module wdtl_cell import wdtl_pkg::*; (
  input  logic      clk_i,
  input  coef_t     x_i,
  input  tap_t      lo_tap_i,
  input  tap_t      hi_tap_i,
  input  sum_pair_t sum_i,
  output sum_pair_t sum_o
);

  prod_t     prod_lo_q, prod_hi_q;
  prod_t     prod_lo_d, prod_hi_d;
  sum_pair_t sum_q, sum_d;

  // Form the products of the broadcast word and add the neighbor's sum to the registered products
  always_comb begin
    prod_lo_d = x_i * lo_tap_i;
    prod_hi_d = x_i * hi_tap_i;
    sum_d.lo  = acc_t'(prod_lo_q) + sum_i.lo;
    sum_d.hi  = acc_t'(prod_hi_q) + sum_i.hi;
  end

  // Advance product and partial sum every cycle
  always_ff @(posedge clk_i) begin
    prod_lo_q <= prod_lo_d;
    prod_hi_q <= prod_hi_d;
    sum_q     <= sum_d;
  end

  assign sum_o = sum_q;

endmodule
`default_nettype wire

@@ rtl/wdtl_filter.sv @@
// Row of sixteen tap cells computing the low-pass and high-pass sums together.
`default_nettype none
module wdtl_filter import wdtl_pkg::*; (
  input  logic      clk_i,
  input  coef_t     x_i,
  output sum_pair_t y_o
);

  sum_pair_t sums [TAPS];
  sum_pair_t feed [TAPS];

  // Chain cells; the far end is fed with zero
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == TAPS - 1) begin : g_end
      assign feed[k] = '0;
    end else begin : g_mid
      assign feed[k] = sums[k+1];
    end
    wdtl_cell u_cell (
      .clk_i    (clk_i),
      .x_i      (x_i),
      .lo_tap_i (LO_TAPS[k]),
      .hi_tap_i (HI_TAPS[k]),
      .sum_i    (feed[k]),
      .sum_o    (sums[k])
    );
  end

  assign y_o = sums[0];

endmodule
`default_nettype wire

@@ rtl/wavelet_decompose_three_level_core.sv @@
// Three-level sym8 wavelet decomposition: sample store, level sequencer, filter row, readout.
// Loads take one word per cycle and reads are answered one per cycle while the result side does not stall;
// a read answers in the cycle after it is accepted. After the final sample, SIZE and BOUND run, then each
// level streams its extended input of len+30 words through the cell row one per cycle, then waits in
// DRAIN for its last results to be written; no word is accepted meanwhile.
// Reset clears control state only; the stores are not cleared and need no clearing pass.
`default_nettype none
module wavelet_decompose_three_level_core import wdtl_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wdtl_in_if.sink     in_chan_i,
  wdtl_out_if.source  out_chan_o
);

  localparam int LEN1        = (MAX_LEN + EXT) / 2;
  localparam int LEN2        = (LEN1 + EXT) / 2;
  localparam int LEN3        = (LEN2 + EXT) / 2;
  localparam int APP_DEPTH   = LEN1 + LEN2;
  localparam int COEFF_DEPTH = 2 * LEN3 + LEN2 + LEN1;
  localparam int SAW         = $clog2(MAX_LEN);
  localparam int AAW         = $clog2(APP_DEPTH);
  localparam int CAW         = $clog2(COEFF_DEPTH);
  localparam int CNTW        = $clog2(MAX_LEN + 1);
  localparam int LW          = $clog2(MAX_LEN + 64) + 1;

  // Stores
  logic signed [15:0] sig_mem   [MAX_LEN];
  coef_t              app_mem   [APP_DEPTH];
  coef_t              coeff_mem [COEFF_DEPTH];

  state_e            state_q, state_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic [CAW-1:0]    rp_q, rp_d;
  logic [1:0]        level_q, level_d;
  logic [LW-1:0]     pos_q, pos_d;
  logic [LW-1:0]     m_q, m_d;
  logic [LW-1:0]     n1_q, n2_q, n3_q, b2_q, b3_q, total_q;
  logic              kp1_q, kp2_q, kp3_q, hi_pend_q;
  coef_t             hi_hold_q;
  logic signed [15:0] sig_rdata_q;
  coef_t             app_rdata_q, coeff_rdata_q;

  logic              out_valid_q, out_valid_d;
  logic              empty_q;
  logic [1:0]        band_q, band_d;
  logic [10:0]       blen_q, blen_d;
  logic              fin_q, fin_d;
  logic [1:0]        status_q;

  logic              acc, in_ready;
  logic [CNTW-1:0]   eff_cnt, ins_cnt;
  logic              eff_ovf, ovf_n;
  logic              sig_we;
  logic [SAW-1:0]    sig_waddr;
  logic              coef_re, resp_load, resp_empty;

  logic [LW-1:0]     len_cur, k_idx, app_off, lo_off, hi_off, hi_base, rp_ext;
  logic [LW+10:0]    blen_wide;
  logic [LW-1:0]     blen_sel;
  logic              pos_last, keep_f, sig_re, app_re;
  logic [LW-1:0]     n1_w, n2_w, n3_w;
  coef_t             x_w, lo_res, hi_res;
  sum_pair_t         y_w;

  assign acc      = in_chan_i.valid && in_ready;
  assign in_ready = (state_q == ST_LOAD || state_q == ST_READ) &&
                    (!out_valid_q || out_chan_o.ready);
  assign in_chan_i.ready = in_ready;

  // Level geometry
  always_comb begin
    case (level_q)
      2'd0:    len_cur = LW'(cnt_q);
      2'd1:    len_cur = n1_q;
      default: len_cur = n2_q;
    endcase
    case (level_q)
      2'd0:    hi_base = b3_q;
      2'd1:    hi_base = b2_q;
      default: hi_base = n3_q;
    endcase
    // Mirror the position into the level input
    if (pos_q < LW'(EXT)) begin
      k_idx = LW'(EXT - 1) - pos_q;
    end else if (pos_q < len_cur + LW'(EXT)) begin
      k_idx = pos_q - LW'(EXT);
    end else begin
      k_idx = (len_cur << 1) + LW'(EXT - 1) - pos_q;
    end
    app_off  = ((level_q == 2'd2) ? LW'(LEN1) : '0) + k_idx;
    lo_off   = ((level_q == 2'd1) ? LW'(LEN1) : '0) + m_q;
    hi_off   = hi_base + m_q;
    pos_last = (pos_q == len_cur + LW'(2 * EXT - 1));
    keep_f   = (state_q == ST_RUN) && !pos_q[0] && (pos_q >= LW'(TAPS));
    sig_re   = (state_q == ST_RUN) && (level_q == 2'd0);
    app_re   = (state_q == ST_RUN) && (level_q != 2'd0);
    n1_w     = (LW'(cnt_q) + LW'(EXT)) >> 1;
    n2_w     = (n1_w + LW'(EXT)) >> 1;
    n3_w     = (n2_w + LW'(EXT)) >> 1;
  end

  // Band lookup for the read pointer
  always_comb begin
    rp_ext = LW'(rp_q);
    if (rp_ext < n3_q) begin
      band_d = BAND_A3; blen_sel = n3_q;
    end else if (rp_ext < b2_q) begin
      band_d = BAND_D3; blen_sel = n3_q;
    end else if (rp_ext < b3_q) begin
      band_d = BAND_D2; blen_sel = n2_q;
    end else begin
      band_d = BAND_D1; blen_sel = n1_q;
    end
    blen_wide = {11'b0, blen_sel};
    blen_d    = blen_wide[10:0];
    fin_d     = (rp_ext + 1'b1 >= total_q);
  end

  // Next state and control
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    rp_d       = rp_q;
    level_d    = level_q;
    pos_d      = pos_q;
    m_d        = hi_pend_q ? m_q + 1'b1 : m_q;
    sig_we     = 1'b0;
    sig_waddr  = '0;
    coef_re    = 1'b0;
    resp_load  = 1'b0;
    resp_empty = 1'b0;
    eff_cnt    = (state_q == ST_READ) ? '0 : cnt_q;
    eff_ovf    = (state_q == ST_READ) ? 1'b0 : ovf_q;
    ins_cnt    = eff_cnt;
    ovf_n      = eff_ovf;
    case (state_q)
      ST_LOAD, ST_READ: begin
        if (acc && in_chan_i.action == ACT_LOAD) begin
          // Store the word or drop it past capacity
          if (eff_cnt < CNTW'(MAX_LEN)) begin
            sig_we    = 1'b1;
            sig_waddr = eff_cnt[SAW-1:0];
            ins_cnt   = eff_cnt + 1'b1;
          end else begin
            ovf_n = 1'b1;
          end
          rp_d    = '0;
          state_d = ST_LOAD;
          cnt_d   = ins_cnt;
          ovf_d   = ovf_n;
          if (in_chan_i.final_sample) begin
            if (ins_cnt >= CNTW'(EXT)) begin
              state_d = ST_SIZE;
            end else begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
          end
        end else if (acc) begin
          resp_load = 1'b1;
          if (state_q == ST_LOAD) begin
            resp_empty = 1'b1;
          end else begin
            coef_re = 1'b1;
            if (fin_d) begin
              state_d = ST_LOAD;
              cnt_d   = '0;
              ovf_d   = 1'b0;
              rp_d    = '0;
            end else begin
              rp_d = rp_q + 1'b1;
            end
          end
        end
      end
      ST_SIZE: begin
        state_d = ST_BOUND;
      end
      ST_BOUND: begin
        level_d = 2'd0;
        pos_d   = '0;
        m_d     = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        pos_d = pos_q + 1'b1;
        if (pos_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Wait for the last results to be written
        if (!(kp1_q || kp2_q || kp3_q || hi_pend_q)) begin
          if (level_q == 2'd2) begin
            state_d = ST_READ;
            rp_d    = '0;
          end else begin
            level_d = level_q + 1'b1;
            pos_d   = '0;
            m_d     = '0;
            state_d = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (resp_load) begin
      out_valid_d = 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rp_q        <= '0;
      level_q     <= '0;
      pos_q       <= '0;
      m_q         <= '0;
      kp1_q       <= 1'b0;
      kp2_q       <= 1'b0;
      kp3_q       <= 1'b0;
      hi_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      rp_q        <= rp_d;
      level_q     <= level_d;
      pos_q       <= pos_d;
      m_q         <= m_d;
      kp1_q       <= keep_f;
      kp2_q       <= kp1_q;
      kp3_q       <= kp2_q;
      hi_pend_q   <= kp3_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Band sizes, latched once per signal
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SIZE) begin
      n1_q <= n1_w;
      n2_q <= n2_w;
      n3_q <= n3_w;
    end
    if (state_q == ST_BOUND) begin
      b2_q    <= n3_q << 1;
      b3_q    <= (n3_q << 1) + n2_q;
      total_q <= (n3_q << 1) + n2_q + n1_q;
    end
  end

  // Response fields
  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      empty_q <= resp_empty;
      if (resp_empty) begin
        band_q   <= BAND_A3;
        blen_q   <= '0;
        fin_q    <= 1'b1;
        status_q <= STATUS_SHORT;
      end else begin
        band_q   <= band_d;
        blen_q   <= blen_d;
        fin_q    <= fin_d;
        status_q <= ovf_q ? STATUS_DROP : STATUS_OK;
      end
    end
  end

  // Signal store
  always_ff @(posedge clk_i) begin
    if (sig_we) begin
      sig_mem[sig_waddr] <= in_chan_i.sample;
    end
    if (sig_re) begin
      sig_rdata_q <= sig_mem[k_idx[SAW-1:0]];
    end
  end

  // Filter row
  assign x_w = (level_q == 2'd0) ? coef_t'({{4{sig_rdata_q[15]}}, sig_rdata_q, 4'b0000})
                                 : app_rdata_q;

  wdtl_filter u_filter (
    .clk_i (clk_i),
    .x_i   (x_w),
    .y_o   (y_w)
  );

  assign lo_res = round_sat(y_w.lo);
  assign hi_res = round_sat(y_w.hi);

  always_ff @(posedge clk_i) begin
    if (kp3_q) begin
      hi_hold_q <= hi_res;
    end
  end

  // Approximation store: written by levels one and two, read by two and three
  always_ff @(posedge clk_i) begin
    if (kp3_q && level_q != 2'd2) begin
      app_mem[lo_off[AAW-1:0]] <= lo_res;
    end
    if (app_re) begin
      app_rdata_q <= app_mem[app_off[AAW-1:0]];
    end
  end

  // Coefficient store: low band of level three; each high result is written in the cycle after, from hi_hold_q
  always_ff @(posedge clk_i) begin
    if (kp3_q && level_q == 2'd2) begin
      coeff_mem[m_q[CAW-1:0]] <= lo_res;
    end else if (hi_pend_q) begin
      coeff_mem[hi_off[CAW-1:0]] <= hi_hold_q;
    end
    if (coef_re) begin
      coeff_rdata_q <= coeff_mem[rp_q];
    end
  end

  assign out_chan_o.valid             = out_valid_q;
  assign out_chan_o.coefficient       = empty_q ? '0 : coeff_rdata_q;
  assign out_chan_o.band              = band_q;
  assign out_chan_o.band_length       = blen_q;
  assign out_chan_o.final_coefficient = fin_q;
  assign out_chan_o.status            = status_q;

  // No word is taken while a decomposition runs
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_DRAIN || state_q == ST_SIZE) |-> !in_ready)
    else $error("ready raised during decomposition");

  // Low and high writes never meet on the coefficient store
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(kp3_q && hi_pend_q))
    else $error("coefficient store write clash");

  // A result only appears after an accepted read
  a_out_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(acc && in_chan_i.action == ACT_READ))
    else $error("result without read");

  // Level change only once the row has drained
  a_level_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q != $past(level_q)) |-> $past(!kp3_q && !hi_pend_q))
    else $error("level advanced with results in flight");

endmodule
`default_nettype wire

@@ test/tb_wdtl_checker.sv @@
// Checker of the wavelet core: watches both channels, predicts results and compares them.
`timescale 1ns / 1ps
module tb_wdtl_checker import wdtl_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  wdtl_in_if   in_w,
  wdtl_out_if  out_w,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct {
    coef_t       coefficient;
    logic [1:0]  band;
    logic [10:0] band_length;
    logic        final_coefficient;
    logic [1:0]  status;
  } coef_word_t;

  coef_word_t  expected_words[$];
  int          signal_q4[$];
  int          coef_seq[$];
  logic        dropped;
  logic        reading;
  int          read_pos;
  int          len_d1, len_d2, len_a3;

  assign pending_o = expected_words.size();

  function automatic int half_of(int len);
    return (len + EXT) / 2;
  endfunction

  // Round a Q20 sum to Q4 and clamp to 24 bits
  function automatic int to_q4(longint sum);
    longint r;
    r = (sum + 64'sd32768) >>> 16;
    if (r > 64'sd8388607) return 8388607;
    if (r < -64'sd8388608) return -8388608;
    return int'(r);
  endfunction

  // One analysis level over a mirror-extended input
  task automatic split_level(input int src[$], output int lo[$], output int hi[$]);
    int     len, k, p;
    longint acc_lo, acc_hi;
    len = src.size();
    lo = {};
    hi = {};
    for (int m = 0; m < half_of(len); m++) begin
      acc_lo = 0;
      acc_hi = 0;
      for (int t = 0; t < TAPS; t++) begin
        p = 2 * m + 1 + t;
        if (p < EXT) k = EXT - 1 - p;
        else if (p < len + EXT) k = p - EXT;
        else k = 2 * len + EXT - 1 - p;
        if (k >= len) k = len - 1;
        acc_lo += longint'(src[k]) * longint'(LO_TAPS[TAPS - 1 - t]);
        acc_hi += longint'(src[k]) * longint'(HI_TAPS[TAPS - 1 - t]);
      end
      lo.push_back(to_q4(acc_lo));
      hi.push_back(to_q4(acc_hi));
    end
  endtask

  task automatic decompose_signal();
    int a1[$], d1[$], a2[$], d2[$], a3[$], d3[$];
    split_level(signal_q4, a1, d1);
    split_level(a1, a2, d2);
    split_level(a2, a3, d3);
    len_d1 = d1.size();
    len_d2 = d2.size();
    len_a3 = a3.size();
    coef_seq = {a3, d3, d2, d1};
  endtask

  task automatic clear_signal();
    signal_q4 = {};
    dropped   = 1'b0;
    reading   = 1'b0;
    read_pos  = 0;
  endtask

  // Predict the answer of one accepted word
  task automatic take_word(logic act, logic signed [15:0] smp, logic fin);
    coef_word_t w;
    if (act == ACT_LOAD) begin
      if (reading) clear_signal();
      if (signal_q4.size() < MAX_LEN) signal_q4.push_back(int'(smp) * 16);
      else dropped = 1'b1;
      if (fin) begin
        if (signal_q4.size() >= EXT) begin
          decompose_signal();
          reading  = 1'b1;
          read_pos = 0;
        end else begin
          clear_signal();
        end
      end
    end else if (!reading) begin
      w = '{coef_t'(0), BAND_A3, 11'd0, 1'b1, STATUS_SHORT};
      expected_words.push_back(w);
    end else begin
      w.coefficient = coef_t'(coef_seq[read_pos]);
      if (read_pos < len_a3) begin
        w.band = BAND_A3; w.band_length = 11'(len_a3);
      end else if (read_pos < 2 * len_a3) begin
        w.band = BAND_D3; w.band_length = 11'(len_a3);
      end else if (read_pos < 2 * len_a3 + len_d2) begin
        w.band = BAND_D2; w.band_length = 11'(len_d2);
      end else begin
        w.band = BAND_D1; w.band_length = 11'(len_d1);
      end
      w.final_coefficient = (read_pos + 1 >= coef_seq.size());
      w.status = dropped ? STATUS_DROP : STATUS_OK;
      expected_words.push_back(w);
      if (w.final_coefficient) clear_signal();
      else read_pos++;
    end
  endtask

  // Compare results first, then advance the prediction
  always @(posedge clk_i or negedge rst_ni) begin
    coef_word_t w;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_words = {};
      clear_signal();
    end else begin
      if (out_w.valid && out_w.ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result word at %0t", $realtime);
          fail_count_o <= fail_count_o + 1;
        end else begin
          w = expected_words.pop_front();
          if (out_w.coefficient !== w.coefficient || out_w.band !== w.band ||
              out_w.band_length !== w.band_length ||
              out_w.final_coefficient !== w.final_coefficient ||
              out_w.status !== w.status) begin
            if (fail_count_o < 10)
              $display("ERROR at %0t: exp c=%0d b=%0d l=%0d f=%0b s=%0d, ",
                       $realtime, w.coefficient, w.band, w.band_length,
                       w.final_coefficient, w.status,
                       "got c=%0d b=%0d l=%0d f=%0b s=%0d",
                       out_w.coefficient, out_w.band, out_w.band_length,
                       out_w.final_coefficient, out_w.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_w.valid && in_w.ready) take_word(in_w.action, in_w.sample, in_w.final_sample);
    end
  end

endmodule

@@ test/tb_wavelet_decompose_three_level_core.sv @@
// Stimulus and verdict for the three-level wavelet core.
`timescale 1ns / 1ps
module tb_wavelet_decompose_three_level_core;
  import wdtl_pkg::*;

  localparam int MAX_LEN   = 1024;
  localparam int CYCLE_CAP = 4000000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   word_count;
  logic no_idle;

  wdtl_in_if  in_if ();
  wdtl_out_if out_if ();

  wavelet_decompose_three_level_core #(.MAX_LEN(MAX_LEN)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if)
  );

  tb_wdtl_checker #(.MAX_LEN(MAX_LEN)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_if),
    .out_w        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Randomly stall the result side
  always @(negedge clk_i or negedge rst_ni) begin
    int stall;
    if (!rst_ni) begin
      out_if.ready = 1'b0;
      stall = 0;
    end else if (stall > 0) begin
      out_if.ready = 1'b0;
      stall--;
    end else begin
      out_if.ready = 1'b1;
      stall = idle_len();
    end
  end

  function automatic int coef_total(int n0);
    int n1, n2, n3;
    n1 = (n0 + EXT) / 2;
    n2 = (n1 + EXT) / 2;
    n3 = (n2 + EXT) / 2;
    return 2 * n3 + n2 + n1;
  endfunction

  // Drive one word and hold it until accepted
  task automatic send_word(logic act, logic signed [15:0] smp, logic fin);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.action       = act;
    in_if.sample       = smp;
    in_if.final_sample = fin;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    word_count++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Load a whole signal; the last word carries the final mark
  task automatic load_signal(int len, int kind);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      case (kind)
        1: s = 16'sh7FFF;
        2: s = 16'sh8000;
        3: s = (i % 2) ? 16'sh7FFF : 16'sh8000;
        default: s = rand_sample();
      endcase
      send_word(ACT_LOAD, s, i == len - 1);
    end
  endtask

  task automatic read_words(int count);
    repeat (count) send_word(ACT_READ, 16'($urandom), 1'($urandom));
  endtask

  initial begin
    int len, pick;
    rst_ni             = 1'b0;
    no_idle            = 1'b0;
    cycle_count        = 0;
    word_count         = 0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_LOAD;
    in_if.sample       = '0;
    in_if.final_sample = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: read with nothing loaded, too-short signal, shortest signal at the rails
    read_words(2);
    load_signal(14, 0);
    read_words(1);
    load_signal(15, 1);
    read_words(3);
    load_signal(15, 2);
    read_words(coef_total(15) + 1);

    // Random: mostly whole signals read out, some abandoned, short or noisy
    while (word_count < 1350) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        len = $urandom_range(MAX_LEN - 3, MAX_LEN + 6);
        load_signal(len, 0);
        read_words(coef_total(len < MAX_LEN ? len : MAX_LEN));
      end else if (pick < 4) begin
        load_signal($urandom_range(15, 40), 3);
        read_words(coef_total(15));
      end else if (pick < 70) begin
        len = $urandom_range(15, 70);
        load_signal(len, 0);
        read_words(coef_total(len) + (($urandom_range(0, 9) == 0) ? 1 : 0));
      end else if (pick < 82) begin
        len = $urandom_range(15, 70);
        load_signal(len, 0);
        read_words($urandom_range(1, coef_total(len) - 1));
      end else if (pick < 90) begin
        load_signal($urandom_range(1, 14), 0);
        read_words($urandom_range(0, 2));
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(1'($urandom), rand_sample(), ($urandom_range(0, 7) == 0));
      end
    end
    in_if.valid = 1'b0;

    wait (pending == 0);
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
